[rtl/core/unique_zero_sum_triplets_defines.svh]
// assertion macros for the triplet finder
`ifndef UNIQUE_ZERO_SUM_TRIPLETS_DEFINES_SVH
`define UNIQUE_ZERO_SUM_TRIPLETS_DEFINES_SVH

// same-cycle implication
`define UZST_ASSERT_NOW(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// next-cycle implication
`define UZST_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

[rtl/core/uzst_pkg.sv]
`default_nettype none
package uzst_pkg;
   localparam int VALUE_BITS = 16;
   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;

   localparam logic [1:0] PH_UNSORTED = 2'd0;
   localparam logic [1:0] PH_ANCHOR = 2'd1;
   localparam logic [1:0] PH_WALK = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [1:0] opcode;
      value_type  value;
   } req_type;

   typedef struct packed {
      logic      found;
      value_type first;
      value_type second;
      value_type third;
      logic      dropped;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic rotate;
   } cell_ctl_type;
endpackage
`default_nettype wire

[rtl/core/unique_zero_sum_triplets.sv]
// channel  ports                        transfer
// request  req_start req_data busy      start high, busy low
// result   rsp_strobe rsp_data          one cycle, strobe high
// clear and load keep busy low; a load inserts into the sorted cell chain
// unless it is full; the first fetch after a clear or a stored load copies
// the chain into a two-read memory by chain rotation, then steps pointers
// and anchors through the memory read
// reset is synchronous; the result side cannot stall
`default_nettype none
module unique_zero_sum_triplets #(
   parameter int CAPACITY = uzst_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_start,
   input  wire uzst_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_strobe,
   output uzst_pkg::rsp_type      rsp_data
);
   import uzst_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_COPY = 4'd1;
   localparam logic [3:0] S_EVAL = 4'd2;
   localparam logic [3:0] S_ANCH = 4'd3;
   localparam logic [3:0] S_WALK = 4'd4;
   localparam logic [3:0] S_SKL_RQ = 4'd5;
   localparam logic [3:0] S_SKL = 4'd6;
   localparam logic [3:0] S_SKH_RQ = 4'd7;
   localparam logic [3:0] S_SKH = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] anchor_ff, anchor_in;
   logic [CW-1:0] low_ff, low_in, high_ff, high_in;
   logic [IW-1:0] copy_ff, copy_in;
   logic          over_ff, over_in;
   value_type     aval_ff, aval_in, prev_ff, prev_in, bval_ff, bval_in;
   value_type     cval_ff, cval_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   value_type     mem [CAPACITY];
   value_type     rd_a, rd_b;
   logic [IW-1:0] rd_a_addr, rd_b_addr;

   cell_ctl_type  ctl;
   logic          cvalid [CAPACITY];
   logic          ccmp [CAPACITY];
   value_type     cvalue [CAPACITY];

   logic          accept;
   logic signed [VALUE_BITS+1:0] sum;
   logic          anchor_end;

   assign accept = req_start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

   assign ctl.clear = accept && (req_data.opcode == OP_CLEAR);
   assign ctl.insert = accept && (req_data.opcode == OP_LOAD) &&
                       (count_ff < CW'(CAPACITY));
   assign ctl.rotate = (state_ff == S_COPY);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      uzst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_value  (req_data.value),
         .prev_valid ((i == 0) ? 1'b1 : cvalid[(i == 0) ? 0 : i - 1]),
         .prev_cmp   ((i == 0) ? 1'b0 : ccmp[(i == 0) ? 0 : i - 1]),
         .prev_value (cvalue[(i == 0) ? 0 : i - 1]),
         .next_valid (cvalid[(i + 1) % CAPACITY]),
         .next_value (cvalue[(i + 1) % CAPACITY]),
         .valid      (cvalid[i]),
         .cmp        (ccmp[i]),
         .value      (cvalue[i])
      );
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_COPY) begin
         mem[copy_ff] <= cvalue[0];
      end
      rd_a <= mem[rd_a_addr];
      rd_b <= mem[rd_b_addr];
   end

   assign sum = (VALUE_BITS+2)'(aval_ff) + (VALUE_BITS+2)'(rd_a) +
                (VALUE_BITS+2)'(rd_b);
   assign anchor_end = (count_ff < CW'(3)) ||
                       ((CW+1)'(anchor_ff) + (CW+1)'(3) > (CW+1)'(count_ff));

   always_comb begin
      rd_a_addr = IW'(low_ff);
      rd_b_addr = IW'(high_ff);
      case (state_ff)
         S_EVAL: begin
            if (phase_ff == PH_ANCHOR) rd_a_addr = anchor_ff;
         end
         S_SKL_RQ: rd_a_addr = IW'(low_ff + CW'(1));
         S_SKH_RQ: rd_b_addr = IW'(high_ff - CW'(1));
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      anchor_in = anchor_ff;
      low_in = low_ff;
      high_in = high_ff;
      copy_in = copy_ff;
      over_in = over_ff;
      aval_in = aval_ff;
      prev_in = prev_ff;
      bval_in = bval_ff;
      cval_in = cval_ff;
      strobe_in = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     over_in = 1'b0;
                     anchor_in = '0;
                     low_in = '0;
                     high_in = '0;
                     phase_in = PH_UNSORTED;
                  end
                  OP_LOAD: begin
                     if (ctl.insert) begin
                        count_in = count_ff + CW'(1);
                        phase_in = PH_UNSORTED;
                     end else begin
                        over_in = 1'b1;
                     end
                  end
                  OP_FETCH: begin
                     if (phase_ff == PH_UNSORTED) begin
                        copy_in = '0;
                        state_in = S_COPY;
                     end else begin
                        state_in = S_EVAL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_COPY: begin
            copy_in = copy_ff + IW'(1);
            if (copy_ff == IW'(CAPACITY - 1)) begin
               anchor_in = '0;
               phase_in = PH_ANCHOR;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (phase_ff)
               PH_DONE: begin
                  strobe_in = 1'b1;
                  rsp_in = '{found: 1'b0, first: '0, second: '0, third: '0,
                             dropped: over_ff};
                  state_in = S_IDLE;
               end
               PH_ANCHOR: begin
                  if (anchor_end) phase_in = PH_DONE;
                  else state_in = S_ANCH;
               end
               default: begin
                  if (low_ff >= high_ff) begin
                     anchor_in = anchor_ff + IW'(1);
                     phase_in = PH_ANCHOR;
                  end else begin
                     state_in = S_WALK;
                  end
               end
            endcase
         end
         S_ANCH: begin
            prev_in = rd_a;
            state_in = S_EVAL;
            if ((anchor_ff != '0) && (rd_a == prev_ff)) begin
               anchor_in = anchor_ff + IW'(1);
            end else begin
               aval_in = rd_a;
               low_in = CW'(anchor_ff) + CW'(1);
               high_in = count_ff - CW'(1);
               phase_in = PH_WALK;
            end
         end
         S_WALK: begin
            state_in = S_EVAL;
            if (sum == '0) begin
               bval_in = rd_a;
               cval_in = rd_b;
               state_in = S_SKL_RQ;
            end else if (sum < 0) begin
               low_in = low_ff + CW'(1);
            end else begin
               high_in = high_ff - CW'(1);
            end
         end
         S_SKL_RQ: begin
            state_in = (low_ff < high_ff) ? S_SKL : S_SKH_RQ;
         end
         S_SKL: begin
            if (rd_a == bval_ff) begin
               low_in = low_ff + CW'(1);
               state_in = S_SKL_RQ;
            end else begin
               state_in = S_SKH_RQ;
            end
         end
         S_SKH_RQ, S_SKH: begin
            if ((state_ff == S_SKH_RQ) && (low_ff < high_ff)) begin
               state_in = S_SKH;
            end else if ((state_ff == S_SKH) && (rd_b == cval_ff)) begin
               high_in = high_ff - CW'(1);
               state_in = S_SKH_RQ;
            end else begin
               low_in = low_ff + CW'(1);
               high_in = high_ff - CW'(1);
               strobe_in = 1'b1;
               rsp_in = '{found: 1'b1, first: aval_ff, second: bval_ff,
                          third: cval_ff, dropped: over_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_UNSORTED;
         count_ff <= '0;
         anchor_ff <= '0;
         low_ff <= '0;
         high_ff <= '0;
         copy_ff <= '0;
         over_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         anchor_ff <= anchor_in;
         low_ff <= low_in;
         high_ff <= high_in;
         copy_ff <= copy_in;
         over_ff <= over_in;
         strobe_ff <= strobe_in;
      end
      aval_ff <= aval_in;
      prev_ff <= prev_in;
      bval_ff <= bval_in;
      cval_ff <= cval_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

[rtl/core/uzst_cell.sv]
`default_nettype none
module uzst_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire uzst_pkg::cell_ctl_type ctl,
   input  wire uzst_pkg::value_type    new_value,
   input  wire logic               prev_valid,
   input  wire logic               prev_cmp,
   input  wire uzst_pkg::value_type    prev_value,
   input  wire logic               next_valid,
   input  wire uzst_pkg::value_type    next_value,
   output logic                    valid,
   output logic                    cmp,
   output uzst_pkg::value_type         value
);
   import uzst_pkg::*;

   value_type value_ff;
   logic      valid_ff;

   assign value = value_ff;
   assign valid = valid_ff;
   assign cmp   = valid_ff && (new_value < value_ff);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.rotate) begin
         valid_ff <= next_valid;
         value_ff <= next_value;
      end else if (ctl.insert) begin
         if (prev_cmp) begin
            valid_ff <= 1'b1;
            value_ff <= prev_value;
         end else if (cmp || (!valid_ff && prev_valid)) begin
            valid_ff <= 1'b1;
            value_ff <= new_value;
         end
      end
   end
endmodule
`default_nettype wire

[rtl/core/uzst_checker.sv]
`default_nettype none
`include "unique_zero_sum_triplets_defines.svh"
module uzst_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire uzst_pkg::rsp_type rsp_data
);
   import uzst_pkg::*;

   logic signed [VALUE_BITS+1:0] tsum;
   assign tsum = (VALUE_BITS+2)'(rsp_data.first) + (VALUE_BITS+2)'(rsp_data.second) +
                 (VALUE_BITS+2)'(rsp_data.third);

   `UZST_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `UZST_ASSERT_NOW(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `UZST_ASSERT_NOW(a_busy_from_start, clock, reset, $rose(busy), $past(req_start))
   `UZST_ASSERT_NOW(a_none_zero, clock, reset, rsp_strobe && !rsp_data.found,
      (rsp_data.first == '0) && (rsp_data.second == '0) && (rsp_data.third == '0))
   `UZST_ASSERT_NOW(a_found_valid, clock, reset, rsp_strobe && rsp_data.found,
      (tsum == '0) && (rsp_data.first <= rsp_data.second) &&
      (rsp_data.second <= rsp_data.third))
endmodule

bind unique_zero_sum_triplets uzst_checker u_uzst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_start  (req_start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
